### rtl/qisc_pkg.sv
// Shared types, constants and codes for the quadratic-interpolation sine/cosine unit.
// Depends on nothing; every other file of the unit but qisc_ram refers to it by scoped names.
package qisc_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_SIN  = 2'd0;
  localparam logic [1:0] KIND_COS  = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;
  localparam logic [1:0] KIND_IDLE = 2'd3;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int FLOAT_W  = 32;
  localparam int SLOT_W   = 8;
  localparam int COEF_W   = 26;

  // Segmentation of the fixed-point angle (23 fraction bits).
  localparam int ANGLE_FRAC  = 23;
  localparam int SEG_BITS    = 5;
  localparam int OFFSET_BITS = ANGLE_FRAC - SEG_BITS;
  localparam int ADDR_W      = SEG_BITS + 1;
  localparam int COEF_DEPTH  = 1 << ADDR_W;
  localparam int ORDERS      = 3;
  localparam logic [SLOT_W-1:0] TABLE_STRIDE = SLOT_W'(ORDERS << SEG_BITS);
  localparam logic [SLOT_W-1:0] STORE_DEPTH  = SLOT_W'(2 * (ORDERS << SEG_BITS));

  // Division by three through a reciprocal, exact for values below 512.
  localparam int RECIP3       = 171;
  localparam int RECIP3_SHIFT = 9;

  // Float handling.
  localparam logic [7:0]  EXP_BIAS  = 8'd127;
  localparam logic [7:0]  EXP_MIN   = 8'd103;
  localparam logic [7:0]  EXP_TOP   = 8'd158;
  localparam logic [23:0] MANT_ONE  = 24'h800000;
  localparam logic [22:0] MANT_MASK = 23'h7fffff;

  // Fixed-point alignment of the polynomial sum.
  localparam int C0_FRAC   = 23;
  localparam int C1_FRAC   = 15;
  localparam int SUM_FRAC  = 57;
  localparam int SUM_W     = 64;
  localparam int C0_SHIFT  = SUM_FRAC - C0_FRAC;
  localparam int C1_SHIFT  = SUM_FRAC - C1_FRAC - ANGLE_FRAC;
  localparam int PROD_W    = COEF_W + OFFSET_BITS;
  localparam int HH_W      = COEF_W + 2 * OFFSET_BITS;
  localparam int POS_W     = 6;
  localparam logic [7:0] EXP_OFFSET = 8'(127 - SUM_FRAC);
  localparam logic [7:0] EXP_ZERO   = 8'd1;

  // Request from the argument stage to the coefficient store and the datapath.
  typedef struct packed {
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ORDERS-1:0]      wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COEF_W-1:0]      wr_data;
    logic [OFFSET_BITS-1:0] h;
    logic                   sine_tab;
    logic                   neg;
  } front_t;

  // Polynomial sum handed to the normaliser.
  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [SUM_W-1:0] sum;
  } poly_out_t;

endpackage

### rtl/qisc_if.sv
// Handshake interfaces for the input and result channels of the sine/cosine unit.
// Depends on qisc_pkg for the payload widths.
interface qisc_in_if;
  logic                          valid;
  logic                          ready;
  logic [qisc_pkg::KIND_W-1:0]   kind;
  logic [qisc_pkg::FLOAT_W-1:0]  x_bits;
  logic [qisc_pkg::SLOT_W-1:0]   coef_slot;
  logic [qisc_pkg::COEF_W-1:0]   coef_value;

  modport source (output valid, kind, x_bits, coef_slot, coef_value, input ready);
  modport sink   (input valid, kind, x_bits, coef_slot, coef_value, output ready);
endinterface

interface qisc_out_if;
  logic                          valid;
  logic                          ready;
  logic [qisc_pkg::FLOAT_W-1:0]  result_bits;

  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface

### rtl/qisc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
module qisc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/qisc_front.sv
// Argument stage: float to fixed-point angle, octant folding, segment and offset,
// and the decode of coefficient load slots. Depends on qisc_pkg.
module qisc_front (
  input  logic                         valid,
  input  logic [qisc_pkg::KIND_W-1:0]  kind,
  input  logic [qisc_pkg::FLOAT_W-1:0] x_bits,
  input  logic [qisc_pkg::SLOT_W-1:0]  coef_slot,
  input  logic [qisc_pkg::COEF_W-1:0]  coef_value,
  output qisc_pkg::front_t             req
);

  logic [7:0]  xexp;
  logic [23:0] mant;
  logic [4:0]  lsh;
  logic [4:0]  rsh;
  logic [31:0] ang_raw;
  logic [31:0] ang;
  logic        b23, b24, b25;
  logic        sine_tab;
  logic        neg;
  logic        is_eval;
  logic        tbl;
  logic [6:0]  rem;
  logic [13:0] rem_prod;
  logic [qisc_pkg::SEG_BITS-1:0] seg_ld;
  logic [1:0]  order;

  // Convert the argument to an angle with 23 fraction bits; out-of-range exponents give 0.
  always_comb begin
    xexp = x_bits[30:23];
    mant = qisc_pkg::MANT_ONE | {1'b0, x_bits[22:0] & qisc_pkg::MANT_MASK};
    lsh  = 5'(xexp - qisc_pkg::EXP_BIAS);
    rsh  = 5'(qisc_pkg::EXP_BIAS - xexp);
    if (xexp >= qisc_pkg::EXP_BIAS && xexp <= qisc_pkg::EXP_TOP) begin
      ang_raw = {8'd0, mant} << lsh;
    end else if (xexp >= qisc_pkg::EXP_MIN && xexp < qisc_pkg::EXP_BIAS) begin
      ang_raw = {8'd0, mant} >> rsh;
    end else begin
      ang_raw = '0;
    end
  end

  // The octant bits choose the table, the sign and whether the angle is complemented.
  always_comb begin
    b23 = ang_raw[23];
    b24 = ang_raw[24];
    b25 = ang_raw[25];
    if (kind == qisc_pkg::KIND_COS) begin
      neg      = b25 ^ b24;
      sine_tab = b23 ^ b24;
    end else begin
      neg      = x_bits[31] ^ b25;
      sine_tab = ~(b23 ^ b24);
    end
    ang = b23 ? (~ang_raw + 32'd1) : ang_raw;
  end

  // Load slots: table, then segment and order by division by three.
  always_comb begin
    tbl      = coef_slot >= qisc_pkg::TABLE_STRIDE;
    rem      = 7'(coef_slot - (tbl ? qisc_pkg::TABLE_STRIDE : '0));
    rem_prod = {7'd0, rem} * 14'(qisc_pkg::RECIP3);
    seg_ld   = rem_prod[qisc_pkg::RECIP3_SHIFT +: qisc_pkg::SEG_BITS];
    order    = 2'(rem - 7'({2'd0, seg_ld} * 7'(qisc_pkg::ORDERS)));
  end

  assign is_eval = valid && (kind == qisc_pkg::KIND_SIN || kind == qisc_pkg::KIND_COS);

  // Request towards the coefficient store and the polynomial datapath.
  always_comb begin
    req          = '0;
    req.rd_en    = is_eval;
    req.rd_addr  = {~sine_tab, ang[qisc_pkg::OFFSET_BITS +: qisc_pkg::SEG_BITS]};
    req.wr_addr  = {tbl, seg_ld};
    req.wr_data  = coef_value;
    req.h        = ang[qisc_pkg::OFFSET_BITS-1:0];
    req.sine_tab = sine_tab;
    req.neg      = neg;
    if (valid && kind == qisc_pkg::KIND_LOAD && coef_slot < qisc_pkg::STORE_DEPTH) begin
      req.wr_en[order] = 1'b1;
    end
  end

endmodule

### rtl/qisc_poly.sv
// Polynomial datapath: products with the offset, then the wrapped 64-bit sum
// C0<<34 +/- (C1*h)<<19 - C2*h*h. Depends on qisc_pkg.
module qisc_poly (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  qisc_pkg::front_t            req,
  input  logic [qisc_pkg::COEF_W-1:0] c0,
  input  logic [qisc_pkg::COEF_W-1:0] c1,
  input  logic [qisc_pkg::COEF_W-1:0] c2,
  output qisc_pkg::poly_out_t         res
);

  // Stage 2: aligned with the coefficient read data.
  logic                            s2_valid_r;
  logic [qisc_pkg::OFFSET_BITS-1:0] s2_h_r;
  logic                            s2_tab_r;
  logic                            s2_neg_r;
  logic [qisc_pkg::PROD_W-1:0]     c1h;
  logic [qisc_pkg::PROD_W-1:0]     c2h;

  // Stage 3.
  logic                            s3_valid_r;
  logic [qisc_pkg::COEF_W-1:0]     s3_c0_r;
  logic [qisc_pkg::PROD_W-1:0]     s3_c1h_r;
  logic [qisc_pkg::PROD_W-1:0]     s3_c2h_r;
  logic [qisc_pkg::OFFSET_BITS-1:0] s3_h_r;
  logic                            s3_tab_r;
  logic                            s3_neg_r;
  logic [qisc_pkg::HH_W-1:0]       hh;

  // Stage 4.
  logic                            s4_valid_r;
  logic [qisc_pkg::COEF_W-1:0]     s4_c0_r;
  logic [qisc_pkg::PROD_W-1:0]     s4_c1h_r;
  logic [qisc_pkg::HH_W-1:0]       s4_hh_r;
  logic                            s4_tab_r;
  logic                            s4_neg_r;
  logic [qisc_pkg::SUM_W-1:0]      c0_al;
  logic [qisc_pkg::SUM_W-1:0]      c1_al;
  logic [qisc_pkg::SUM_W-1:0]      sum_nxt;

  // Stage 5 output.
  logic                            s5_valid_r;
  logic                            s5_neg_r;
  logic [qisc_pkg::SUM_W-1:0]      s5_sum_r;

  // First products with the offset.
  assign c1h = qisc_pkg::PROD_W'(c1) * qisc_pkg::PROD_W'(s2_h_r);
  assign c2h = qisc_pkg::PROD_W'(c2) * qisc_pkg::PROD_W'(s2_h_r);

  // Second product gives C2*h*h.
  assign hh = qisc_pkg::HH_W'(s3_c2h_r) * qisc_pkg::HH_W'(s3_h_r);

  // Aligned sum; the cosine table subtracts the linear term.
  always_comb begin
    c0_al = qisc_pkg::SUM_W'(s4_c0_r) << qisc_pkg::C0_SHIFT;
    c1_al = qisc_pkg::SUM_W'(s4_c1h_r) << qisc_pkg::C1_SHIFT;
    if (s4_tab_r) begin
      sum_nxt = c0_al + c1_al - qisc_pkg::SUM_W'(s4_hh_r);
    end else begin
      sum_nxt = c0_al - c1_al - qisc_pkg::SUM_W'(s4_hh_r);
    end
  end

  // Valid flags of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= req.rd_en;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // Payload registers of the stages.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_h_r   <= req.h;
      s2_tab_r <= req.sine_tab;
      s2_neg_r <= req.neg;
      s3_c0_r  <= c0;
      s3_c1h_r <= c1h;
      s3_c2h_r <= c2h;
      s3_h_r   <= s2_h_r;
      s3_tab_r <= s2_tab_r;
      s3_neg_r <= s2_neg_r;
      s4_c0_r  <= s3_c0_r;
      s4_c1h_r <= s3_c1h_r;
      s4_hh_r  <= hh;
      s4_tab_r <= s3_tab_r;
      s4_neg_r <= s3_neg_r;
      s5_sum_r <= sum_nxt;
      s5_neg_r <= s4_neg_r;
    end
  end

  always_comb begin
    res.valid = s5_valid_r;
    res.neg   = s5_neg_r;
    res.sum   = s5_sum_r;
  end

endmodule

### rtl/qisc_norm.sv
// Normaliser: leading-one detect over the 64-bit sum, truncating shift and float
// packing into the result register. Depends on qisc_pkg.
module qisc_norm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  qisc_pkg::poly_out_t          sum_in,
  output logic                         out_valid,
  output logic [qisc_pkg::FLOAT_W-1:0] out_bits
);

  logic [7:0]                  grp_hit;
  logic [2:0]                  grp_idx;
  logic [7:0]                  grp_byte;
  logic [2:0]                  bit_idx;
  logic [qisc_pkg::POS_W-1:0]  pos;

  logic                        s6_valid_r;
  logic                        s6_neg_r;
  logic                        s6_zero_r;
  logic [qisc_pkg::POS_W-1:0]  s6_pos_r;
  logic [qisc_pkg::SUM_W-1:0]  s6_sum_r;

  logic [qisc_pkg::SUM_W+22:0] wide;
  logic [22:0]                 man;
  logic [7:0]                  ex;
  logic [qisc_pkg::FLOAT_W-1:0] result_nxt;

  logic                         out_valid_r;
  logic [qisc_pkg::FLOAT_W-1:0] out_bits_r;

  // Leading one in two levels: the highest non-zero byte, then the highest bit in it.
  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_hit[g] = |sum_in.sum[g*8 +: 8];
    end
    grp_idx = '0;
    for (int g = 0; g < 8; g++) begin
      if (grp_hit[g]) begin
        grp_idx = 3'(g);
      end
    end
    grp_byte = sum_in.sum[grp_idx*8 +: 8];
    bit_idx  = '0;
    for (int b = 0; b < 8; b++) begin
      if (grp_byte[b]) begin
        bit_idx = 3'(b);
      end
    end
    pos = {grp_idx, bit_idx};
  end

  // The 23 bits below the leading one, zero-filled when it sits low.
  always_comb begin
    wide       = {s6_sum_r, 23'd0} >> s6_pos_r;
    man        = s6_zero_r ? 23'd0 : (wide[22:0] & qisc_pkg::MANT_MASK);
    ex         = s6_zero_r ? qisc_pkg::EXP_ZERO
                           : 8'(qisc_pkg::EXP_OFFSET + {2'd0, s6_pos_r});
    result_nxt = {s6_neg_r, ex, man};
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r  <= sum_in.valid;
      out_valid_r <= s6_valid_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      s6_sum_r   <= sum_in.sum;
      s6_neg_r   <= sum_in.neg;
      s6_zero_r  <= ~|grp_hit;
      s6_pos_r   <= pos;
      out_bits_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bits  = out_bits_r;

endmodule

### rtl/quadratic_interp_sin_cos_unit_core.sv
// A sine or cosine transaction passes the input register, stages 2 to 6 and the result register.
// Throughput: one transaction per cycle; the whole pipeline advances together and holds
// while a finished result waits on the result channel.
// Reset (synchronous, active low) clears every stage valid flag; the coefficient store
// is not cleared and must be loaded before it is read.
// Depends on qisc_pkg, qisc_if, qisc_ram, qisc_front, qisc_poly and qisc_norm.
module quadratic_interp_sin_cos_unit_core (
  input  logic            clk,
  input  logic            rst_n,
  qisc_in_if.sink         in_ch,
  qisc_out_if.source      out_ch
);

  logic                          en;
  logic                          s1_valid_r;
  logic [qisc_pkg::KIND_W-1:0]   s1_kind_r;
  logic [qisc_pkg::FLOAT_W-1:0]  s1_x_r;
  logic [qisc_pkg::SLOT_W-1:0]   s1_slot_r;
  logic [qisc_pkg::COEF_W-1:0]   s1_value_r;
  qisc_pkg::front_t              req;
  logic [qisc_pkg::COEF_W-1:0]   coef [qisc_pkg::ORDERS];
  qisc_pkg::poly_out_t           poly_res;
  logic                          out_valid;
  logic [qisc_pkg::FLOAT_W-1:0]  out_bits;

  // The pipeline moves whenever the result register is free or being emptied.
  assign en          = !out_valid || out_ch.ready;
  assign in_ch.ready = en;

  // Input stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r  <= in_ch.kind;
      s1_x_r     <= in_ch.x_bits;
      s1_slot_r  <= in_ch.coef_slot;
      s1_value_r <= in_ch.coef_value;
    end
  end

  qisc_front u_front (
    .valid      (s1_valid_r),
    .kind       (s1_kind_r),
    .x_bits     (s1_x_r),
    .coef_slot  (s1_slot_r),
    .coef_value (s1_value_r),
    .req        (req)
  );

  // One coefficient store per polynomial order, addressed by table and segment.
  // Loads and reads leave the same stage in order, so a read always sees earlier loads.
  for (genvar i = 0; i < qisc_pkg::ORDERS; i++) begin : g_coef
    qisc_ram #(
      .WIDTH (qisc_pkg::COEF_W),
      .DEPTH (qisc_pkg::COEF_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (en && req.wr_en[i]),
      .waddr (req.wr_addr),
      .wdata (req.wr_data),
      .re    (en && req.rd_en),
      .raddr (req.rd_addr),
      .rdata (coef[i])
    );
  end

  qisc_poly u_poly (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .req   (req),
    .c0    (coef[0]),
    .c1    (coef[1]),
    .c2    (coef[2]),
    .res   (poly_res)
  );

  qisc_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .sum_in    (poly_res),
    .out_valid (out_valid),
    .out_bits  (out_bits)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.result_bits = out_bits;

  // A load writes at most one order store.
  a_one_store_written: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(req.wr_en))
    else $error("coefficient load writes more than one store");

  // A transaction either loads or reads the store, never both.
  a_no_read_and_write: assert property (@(posedge clk) disable iff (!rst_n)
    req.rd_en |-> (req.wr_en == '0))
    else $error("coefficient store read and written by one transaction");

  // Every result carries the zero-sum exponent or one inside the normalised range.
  a_result_exponent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.result_bits[30:23] == qisc_pkg::EXP_ZERO ||
                      (out_ch.result_bits[30:23] >= qisc_pkg::EXP_OFFSET &&
                       out_ch.result_bits[30:23] <= 8'(qisc_pkg::EXP_OFFSET + 8'd63))))
    else $error("result exponent outside the normalised range");

endmodule
